/* rtl/core/integer_field_formatter_macros.svh */
// Assertion macros for the integer field formatter RTL, used by iff_emit.
// Requires aclk and aresetn in the scope of the module that uses them.
`ifndef INTEGER_FIELD_FORMATTER_MACROS_SVH
`define INTEGER_FIELD_FORMATTER_MACROS_SVH

// Check cons in the same cycle as ante.
`define IFF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define IFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/iff_pkg.sv */
// Package for the integer field formatter: mode codes, ASCII constants,
// the emitter load record and the digit-to-character function. No dependencies.
package iff_pkg;

    localparam int VALUE_W       = 32;
    localparam int FW_W          = 6;
    localparam int DEF_MAX_WIDTH = 32;
    localparam int BCD_DIGITS    = 10;
    localparam int HEX_DIGITS    = 8;
    localparam int DIG_W         = 4 * BCD_DIGITS;
    localparam int NDIG_W        = 4;

    typedef enum logic [2:0] {
        MODE_SDEC = 3'd0,
        MODE_UDEC = 3'd1,
        MODE_HEXL = 3'd2,
        MODE_HEXU = 3'd3,
        MODE_CHAR = 3'd4,
        MODE_PCT  = 3'd5,
        MODE_PTR  = 3'd6,
        MODE_UNK  = 3'd7
    } iff_mode_t;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [15:0]        pfx;
        logic [1:0]         pfx_len;
        logic [DIG_W-1:0]   digits;
        logic [NDIG_W-1:0]  ndig;
        logic               upper;
    } iff_load_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'h0, d};
        end
        base = upper ? CHAR_UA : CHAR_LA;
        return base + {4'h0, d} - 8'd10;
    endfunction

endpackage

/* rtl/core/iff_dabble.sv */
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
// Depends on iff_pkg.
module iff_dabble import iff_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] mag,
    output logic               done,
    output logic [DIG_W-1:0]   bcd
);

    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0] bin_reg;
    logic [DIG_W-1:0]   bcd_reg;
    logic [DIG_W-1:0]   adj;

    always_comb begin
        adj = bcd_reg;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= mag;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {adj[DIG_W-2:0], bin_reg[VALUE_W-1]};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

/* rtl/core/iff_emit.sv */
// Character emitter: drops leading zero digits, pads, then shifts out prefix
// and digits one character per cycle, unless m_ready stalls, into the output register. Depends on iff_pkg.
`include "integer_field_formatter_macros.svh"
module iff_emit import iff_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ld_valid,
    input  iff_load_t     ld,
    input  logic [WW-1:0] ld_width,
    output logic          done,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_char,
    output logic          m_last
);

    localparam int CW = WW + 1;

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_NORM = 3'b010,
        E_EMIT = 3'b100
    } emit_state_t;

    emit_state_t        state_reg;
    logic [15:0]        pfx_reg;
    logic [1:0]         pfx_cnt_reg;
    logic [DIG_W-1:0]   dig_reg;
    logic [NDIG_W-1:0]  dig_cnt_reg;
    logic               upper_reg;
    logic [WW-1:0]      width_reg;
    logic [CW-1:0]      pad_reg;
    logic [CW-1:0]      rem_reg;
    logic               m_valid_reg;
    logic [7:0]         m_char_reg;
    logic               m_last_reg;

    logic               out_load;
    logic               strip;
    logic [CW-1:0]      len;
    logic [CW-1:0]      wid;
    logic [CW-1:0]      pad_next;
    logic [7:0]         char_next;

    assign out_load = (state_reg == E_EMIT) && (!m_valid_reg || m_ready);
    assign strip    = (dig_cnt_reg > NDIG_W'(1)) && (dig_reg[DIG_W-1 -: 4] == 4'h0);
    assign len      = CW'(pfx_cnt_reg) + CW'(dig_cnt_reg);
    assign wid      = CW'(width_reg);
    assign pad_next = (wid > len) ? (wid - len) : '0;
    assign done     = out_load && (rem_reg == CW'(1));

    always_comb begin
        if (pad_reg != '0) begin
            char_next = CHAR_SPACE;
        end else if (pfx_cnt_reg != 2'd0) begin
            char_next = pfx_reg[15:8];
        end else begin
            char_next = digit_char(dig_reg[DIG_W-1 -: 4], upper_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                E_IDLE: begin
                    if (ld_valid) begin
                        state_reg <= E_NORM;
                    end
                end
                E_NORM: begin
                    if (!strip) begin
                        state_reg <= E_EMIT;
                    end
                end
                E_EMIT: begin
                    if (done) begin
                        state_reg <= E_IDLE;
                    end
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == E_IDLE && ld_valid) begin
            pfx_reg     <= ld.pfx;
            pfx_cnt_reg <= ld.pfx_len;
            dig_reg     <= ld.digits;
            dig_cnt_reg <= ld.ndig;
            upper_reg   <= ld.upper;
            width_reg   <= ld_width;
        end else if (state_reg == E_NORM) begin
            if (strip) begin
                dig_reg     <= {dig_reg[DIG_W-5:0], 4'h0};
                dig_cnt_reg <= dig_cnt_reg - NDIG_W'(1);
            end else begin
                pad_reg <= pad_next;
                rem_reg <= pad_next + len;
            end
        end else if (out_load) begin
            m_char_reg <= char_next;
            m_last_reg <= (rem_reg == CW'(1));
            rem_reg    <= rem_reg - CW'(1);
            if (pad_reg != '0) begin
                pad_reg <= pad_reg - CW'(1);
            end else if (pfx_cnt_reg != 2'd0) begin
                pfx_reg     <= {pfx_reg[7:0], 8'h00};
                pfx_cnt_reg <= pfx_cnt_reg - 2'd1;
            end else begin
                dig_reg     <= {dig_reg[DIG_W-5:0], 4'h0};
                dig_cnt_reg <= dig_cnt_reg - NDIG_W'(1);
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_last     = m_last_reg;

    `IFF_ASSERT_SAME(a_emit_rem, state_reg == E_EMIT, rem_reg != '0, "emit with no characters left")
    `IFF_ASSERT_SAME(a_load_idle, ld_valid, state_reg == E_IDLE, "load while emitter busy")
    `IFF_ASSERT_NEXT(a_last_idle, done, (state_reg == E_IDLE) && m_valid && m_last, "final character not flagged")

endmodule

/* rtl/core/integer_field_formatter.sv */
// Top level of the integer field formatter: input capture, mode decode and sequencing.
// Depends on iff_pkg, iff_dabble and iff_emit.
//
//   channel | ports                                             | direction
//   input   | s_valid s_ready s_action s_value s_field_width s_spec_char | in
//   result  | m_valid m_ready m_out_char m_last                 | out
//
// One transaction in at a time; s_ready is high only while the sequencer is idle.
// Decimal: input capture, binary-to-BCD conversion and handoff, then per-digit zero strip
// (up to 9 digits), a setup step and emission of one character per cycle unless stalled.
// Hex and pointer skip the converter (zero strip up to 7 digits); other modes have no digits to strip.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// A stalled m_ready holds the output register and stops character emission.
module integer_field_formatter import iff_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic [VALUE_W-1:0] s_value,
    input  logic [FW_W-1:0]    s_field_width,
    input  logic [7:0]         s_spec_char,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_char,
    output logic               m_last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } top_state_t;

    top_state_t         state_reg;
    iff_load_t          pend_reg;
    logic [WW-1:0]      width_reg;

    iff_mode_t          mode;
    logic               accept;
    logic               neg;
    logic               is_dec;
    logic [WW-1:0]      width_sat;
    logic [VALUE_W-1:0] mag;
    iff_load_t          ld_direct;
    iff_load_t          ld;
    logic [WW-1:0]      ld_width;
    logic               ld_valid;
    logic               dab_done;
    logic [DIG_W-1:0]   dab_bcd;
    logic               emit_done;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign mode      = iff_mode_t'(s_action);
    assign neg       = s_value[VALUE_W-1];
    assign is_dec    = mode inside {MODE_SDEC, MODE_UDEC};
    assign mag       = (mode == MODE_SDEC && neg) ? (VALUE_W'(0) - s_value) : s_value;
    assign width_sat = (int'(s_field_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(s_field_width);

    always_comb begin
        ld_direct         = '0;
        ld_direct.digits  = {s_value, 8'h00};
        case (mode)
            MODE_SDEC: begin
                ld_direct.pfx     = {CHAR_MINUS, 8'h00};
                ld_direct.pfx_len = neg ? 2'd1 : 2'd0;
            end
            MODE_UDEC: begin
                ld_direct.pfx_len = 2'd0;
            end
            MODE_HEXL: begin
                ld_direct.ndig = NDIG_W'(HEX_DIGITS);
            end
            MODE_HEXU: begin
                ld_direct.ndig  = NDIG_W'(HEX_DIGITS);
                ld_direct.upper = 1'b1;
            end
            MODE_CHAR: begin
                ld_direct.pfx     = {s_value[7:0], 8'h00};
                ld_direct.pfx_len = 2'd1;
            end
            MODE_PCT: begin
                ld_direct.pfx     = {CHAR_PCT, 8'h00};
                ld_direct.pfx_len = 2'd1;
            end
            MODE_PTR: begin
                ld_direct.pfx     = {CHAR_ZERO, CHAR_X};
                ld_direct.pfx_len = 2'd2;
                ld_direct.ndig    = NDIG_W'(HEX_DIGITS);
            end
            default: begin
                ld_direct.pfx     = {CHAR_PCT, s_spec_char};
                ld_direct.pfx_len = 2'd2;
            end
        endcase
    end

    always_comb begin
        if (state_reg == ST_CONV) begin
            ld        = pend_reg;
            ld.digits = dab_bcd;
            ld.ndig   = NDIG_W'(BCD_DIGITS);
            ld_width  = width_reg;
            ld_valid  = dab_done;
        end else begin
            ld        = ld_direct;
            ld_width  = width_sat;
            ld_valid  = accept && !is_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= is_dec ? ST_CONV : ST_EMIT;
                    end
                end
                ST_CONV: begin
                    if (dab_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg  <= ld_direct;
            width_reg <= width_sat;
        end
    end

    iff_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && is_dec),
        .mag     (mag),
        .done    (dab_done),
        .bcd     (dab_bcd)
    );

    iff_emit #(
        .MAX_WIDTH (MAX_WIDTH),
        .WW        (WW)
    ) u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ld_valid   (ld_valid),
        .ld         (ld),
        .ld_width   (ld_width),
        .done       (emit_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

/* verif/integer_field_formatter_tb.sv */
// Testbench for integer_field_formatter: drives printf-style conversion requests,
// predicts every output character and checks it along with its last flag.
// Depends on iff_pkg and the integer_field_formatter RTL.
module integer_field_formatter_tb import iff_pkg::*; ();

    localparam int FIELD_MAX    = DEF_MAX_WIDTH;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [2:0]         s_action      = '0;
    logic [VALUE_W-1:0] s_value       = '0;
    logic [FW_W-1:0]    s_field_width = '0;
    logic [7:0]         s_spec_char   = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [7:0]         m_out_char;
    logic               m_last;

    char_beat_t  expected_chars[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned src_max_gap    = 10;
    int unsigned sink_max_stall = 10;
    bit          hold_req       = 1'b0;

    integer_field_formatter #(.MAX_WIDTH(FIELD_MAX)) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_value       (s_value),
        .s_field_width (s_field_width),
        .s_spec_char   (s_spec_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last        (m_last)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("integer_field_formatter regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic void predict_conversion(input iff_mode_t mode, input logic [31:0] value,
                                               input logic [5:0] fw, input logic [7:0] spec);
        logic [7:0]  text [0:15];
        logic [7:0]  rev [0:11];
        logic [31:0] mag;
        logic [7:0]  alpha;
        logic [3:0]  d;
        int unsigned radix, len, nd, k, w, pad, total;
        char_beat_t  beat;
        len   = 0;
        radix = 0;
        alpha = CHAR_LA;
        mag   = value;
        case (mode)
            MODE_SDEC: begin
                radix = 10;
                if (value[31]) begin
                    text[0] = CHAR_MINUS;
                    len     = 1;
                    mag     = 32'd0 - value;
                end
            end
            MODE_UDEC: radix = 10;
            MODE_HEXL: radix = 16;
            MODE_HEXU: begin
                radix = 16;
                alpha = CHAR_UA;
            end
            MODE_CHAR: begin
                text[0] = value[7:0];
                len     = 1;
            end
            MODE_PCT: begin
                text[0] = CHAR_PCT;
                len     = 1;
            end
            MODE_PTR: begin
                text[0] = CHAR_ZERO;
                text[1] = CHAR_X;
                len     = 2;
                radix   = 16;
            end
            default: begin
                text[0] = CHAR_PCT;
                text[1] = spec;
                len     = 2;
            end
        endcase
        if (radix != 0) begin
            nd = 0;
            do begin
                d       = 4'(mag % radix);
                rev[nd] = (d < 4'd10) ? 8'(CHAR_ZERO + d) : 8'(alpha + d - 8'd10);
                mag     = mag / radix;
                nd++;
            end while (mag != 0);
            for (k = 0; k < nd; k++) begin
                text[len + k] = rev[nd - 1 - k];
            end
            len += nd;
        end
        w     = (fw > FIELD_MAX) ? FIELD_MAX : fw;
        pad   = (w > len) ? w - len : 0;
        total = pad + len;
        for (k = 0; k < total; k++) begin
            beat.ch   = (k < pad) ? CHAR_SPACE : text[k - pad];
            beat.last = (k + 1 == total);
            expected_chars.push_back(beat);
        end
    endfunction

    task automatic send_conversion(input iff_mode_t mode, input logic [31:0] value,
                                   input logic [5:0] fw, input logic [7:0] spec);
        int unsigned gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= mode;
        s_value       <= value;
        s_field_width <= fw;
        s_spec_char   <= spec;
        do @(posedge aclk); while (!s_ready);
        predict_conversion(mode, value, fw, spec);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return 32'h8000_0000 + $urandom_range(0, 15);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            3: return 32'd1 << $urandom_range(0, 31);
            4: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] random_width();
        if ($urandom_range(0, 7) == 0) begin
            return 6'($urandom_range(0, 63));
        end
        return 6'($urandom_range(0, 14));
    endfunction

    initial begin : sink_proc
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                stall = $urandom_range(0, sink_max_stall);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : check_chars
        char_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last %0d",
                                          m_out_char, m_last));
            end else begin
                want = expected_chars.pop_front();
                if (m_out_char !== want.ch) begin
                    report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                              m_out_char, want.ch));
                end
                if (m_last !== want.last) begin
                    report_mismatch($sformatf("last %0d, expected %0d on char 0x%02h",
                                              m_last, want.last, want.ch));
                end
            end
        end
    end

    task automatic test_directed_edges();
        send_conversion(MODE_SDEC, 32'd0, 6'd0, 8'h00);
        send_conversion(MODE_SDEC, 32'hFFFF_FFFF, 6'd0, 8'h00);
        send_conversion(MODE_SDEC, 32'h7FFF_FFFF, 6'd0, 8'h00);
        send_conversion(MODE_SDEC, 32'h8000_0000, 6'd0, 8'h00);
        send_conversion(MODE_SDEC, 32'h8000_0000, 6'd11, 8'h00);
        send_conversion(MODE_UDEC, 32'd0, 6'd1, 8'h00);
        send_conversion(MODE_UDEC, 32'hFFFF_FFFF, 6'd5, 8'h00);
        send_conversion(MODE_HEXL, 32'd0, 6'd0, 8'h00);
        send_conversion(MODE_HEXL, 32'hDEAD_BEEF, 6'd12, 8'h00);
        send_conversion(MODE_HEXU, 32'hFFFF_FFFF, 6'd0, 8'h00);
        send_conversion(MODE_HEXU, 32'hABCD_EF01, 6'd9, 8'h00);
        send_conversion(MODE_CHAR, 32'hFFFF_FF00, 6'd0, 8'h00);
        send_conversion(MODE_CHAR, 32'h1234_5641, 6'd3, 8'hFF);
        send_conversion(MODE_CHAR, 32'h0000_00FF, 6'd1, 8'h00);
        send_conversion(MODE_PCT, 32'hFFFF_FFFF, 6'd0, 8'hFF);
        send_conversion(MODE_PCT, 32'd0, 6'd2, 8'h00);
        send_conversion(MODE_PTR, 32'd0, 6'd0, 8'h00);
        send_conversion(MODE_PTR, 32'hFFFF_FFFF, 6'd0, 8'h00);
        send_conversion(MODE_UNK, 32'd0, 6'd0, 8'h00);
        send_conversion(MODE_UNK, 32'hFFFF_FFFF, 6'd4, 8'hFF);
        send_conversion(MODE_UDEC, 32'd7, 6'd32, 8'h00);
        send_conversion(MODE_HEXL, 32'd7, 6'd33, 8'h00);
        send_conversion(MODE_SDEC, 32'hFFFF_FFF6, 6'h3F, 8'hAA);
        send_conversion(MODE_PTR, 32'h0000_BEEF, 6'd40, 8'h55);
    endtask

    task automatic test_random_mix(input int unsigned n_items);
        int unsigned i;
        for (i = 0; i < n_items; i++) begin
            if (i % 50 == 0) begin
                src_max_gap    = ($urandom_range(0, 2) == 0) ? 0 : 10;
                sink_max_stall = ($urandom_range(0, 2) == 0) ? 0 : 10;
            end
            send_conversion(iff_mode_t'($urandom_range(0, 7)), random_word(),
                            random_width(), 8'($urandom_range(0, 255)));
        end
        src_max_gap    = 10;
        sink_max_stall = 10;
    endtask

    task automatic test_back_to_back(input int unsigned n_items);
        int unsigned i;
        src_max_gap    = 0;
        sink_max_stall = 0;
        for (i = 0; i < n_items; i++) begin
            send_conversion(iff_mode_t'($urandom_range(0, 7)), random_word(),
                            random_width(), 8'($urandom_range(0, 255)));
        end
        src_max_gap    = 10;
        sink_max_stall = 10;
    endtask

    task automatic test_receiver_hold_off(input int unsigned n_items);
        int unsigned i;
        src_max_gap = 0;
        hold_req    = 1'b1;
        for (i = 0; i < n_items; i++) begin
            send_conversion(iff_mode_t'($urandom_range(0, 7)), random_word(),
                            6'($urandom_range(20, 40)), 8'($urandom_range(0, 255)));
        end
        src_max_gap = 10;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_edges();
        test_random_mix(400);
        test_back_to_back(48);
        test_receiver_hold_off(8);
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
        end
        if (mismatch_count == 0) begin
            $display("integer_field_formatter regression: pass");
        end else begin
            $display("integer_field_formatter regression: fail");
        end
        $finish;
    end

endmodule
